// File: rtl/mbp_pkg.sv
// Package for the Manchester byte packer: segment sizing constants,
// line codes and the control and status structs between the modules.
// No dependencies.
`timescale 1ns / 1ps

package mbp_pkg;

    localparam int SEGMENT_WIDTH = 64;
    localparam int CNT_W = $clog2(SEGMENT_WIDTH + 1);
    localparam int IDX_W = $clog2(SEGMENT_WIDTH);
    localparam int PAIRS_PER_BYTE = 4;

    localparam logic [1:0] LINE_ONE  = 2'b10;
    localparam logic [1:0] LINE_ZERO = 2'b01;

    typedef struct packed {
        logic step;
        logic clear;
        logic data_bit;
    } mbp_coder_ctrl_t;

    typedef struct packed {
        logic       byte_full;
        logic [7:0] byte_value;
        logic [7:0] partial;
        logic [1:0] pending;
    } mbp_coder_stat_t;

endpackage

// File: rtl/mbp_coder.sv
// Shared coding unit: merges one Manchester pair per step into the partial byte.
// Depends on mbp_pkg.
`timescale 1ns / 1ps

module mbp_coder import mbp_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  mbp_coder_ctrl_t ctrl,
    output mbp_coder_stat_t stat
);

    logic [7:0] partial_reg, partial_next;
    logic [1:0] pending_reg, pending_next;
    logic [1:0] pair;
    logic [7:0] merged;

    assign pair = ctrl.data_bit ? LINE_ONE : LINE_ZERO;

    always_comb begin
        merged = partial_reg;
        unique case (pending_reg)
            2'd0: merged[7:6] = pair;
            2'd1: merged[5:4] = pair;
            2'd2: merged[3:2] = pair;
            2'd3: merged[1:0] = pair;
            default: merged = partial_reg;
        endcase
    end

    always_comb begin
        partial_next = partial_reg;
        pending_next = pending_reg;
        if (ctrl.clear) begin
            partial_next = '0;
            pending_next = '0;
        end else if (ctrl.step) begin
            if (pending_reg == 2'd3) begin
                partial_next = '0;
                pending_next = '0;
            end else begin
                partial_next = merged;
                pending_next = pending_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            pending_reg <= '0;
        end else begin
            partial_reg <= partial_next;
            pending_reg <= pending_next;
        end
    end

    assign stat.byte_full  = (pending_reg == 2'd3);
    assign stat.byte_value = merged;
    assign stat.partial    = partial_reg;
    assign stat.pending    = pending_reg;

endmodule

// File: rtl/manchester_byte_packer.sv
// Manchester byte packer, top level: segment sequencer and output register.
// Throughput: the single coding unit handles one data bit per cycle, except while a
// completed byte waits for the output register; a new segment is taken only in IDLE.
// A full byte is registered into the output by the step that codes its fourth pair;
// a short final segment is padded and its partial byte goes out from the FLUSH state.
// Reset (synchronous, aresetn low) empties the packer and drops any waiting byte.
// Depends on mbp_pkg and mbp_coder.
`timescale 1ns / 1ps

module manchester_byte_packer import mbp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata, lowest bit up: data_word[63:0], bit_count[70:64], zero pad [71]
    input  logic [71:0] s_tdata,
    input  logic        s_tvalid,
    input  logic        s_tlast,      // final_segment
    output logic        s_tready,
    // m_tdata, lowest bit up: line_byte[7:0]
    output logic [7:0]  m_tdata,
    output logic        m_tvalid,
    output logic        m_tlast,      // run_end
    input  logic        m_tready
);

    typedef enum logic [1:0] {
        IDLE,
        RUN,
        FLUSH
    } state_t;

    localparam logic [CNT_W-1:0] SEG_MAX   = CNT_W'(SEGMENT_WIDTH);
    localparam logic [CNT_W-1:0] PAIRS_MAX = CNT_W'(PAIRS_PER_BYTE);

    state_t                   state_reg, state_next;
    logic [SEGMENT_WIDTH-1:0] data_reg, data_next;
    logic [CNT_W-1:0]         rem_reg, rem_next;
    logic                     final_reg, final_next;
    logic                     m_valid_reg, m_valid_next;
    logic [7:0]               m_data_reg, m_data_next;
    logic                     m_last_reg, m_last_next;

    mbp_coder_ctrl_t coder_ctrl;
    mbp_coder_stat_t coder_stat;

    logic [6:0]       in_count;
    logic [CNT_W-1:0] sat_count;
    logic [CNT_W-1:0] rem_after;
    logic [IDX_W-1:0] bit_idx;
    logic             out_free;
    logic             more_bytes;

    assign in_count  = s_tdata[70:64];
    // Counts beyond the segment width saturate to the segment width.
    assign sat_count = (in_count > 7'(SEGMENT_WIDTH)) ? SEG_MAX : in_count[CNT_W-1:0];

    // The data bit under the cursor: bits are taken from the top of the count down.
    assign rem_after = rem_reg - 1'b1;
    assign bit_idx   = rem_after[IDX_W-1:0];

    // The output register may take a new byte when it is empty or being drained.
    assign out_free = !m_valid_reg || m_tready;

    // Another byte follows this one if at least a full byte of bits remains, or if
    // any bits remain and the segment is final so they get flushed.
    assign more_bytes = (rem_after >= PAIRS_MAX) || (final_reg && (rem_after != '0));

    mbp_coder u_coder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (coder_ctrl),
        .stat    (coder_stat)
    );

    always_comb begin
        state_next   = state_reg;
        data_next    = data_reg;
        rem_next     = rem_reg;
        final_next   = final_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        coder_ctrl.step     = 1'b0;
        coder_ctrl.clear    = 1'b0;
        coder_ctrl.data_bit = data_reg[bit_idx];

        unique case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    data_next  = s_tdata[SEGMENT_WIDTH-1:0];
                    rem_next   = sat_count;
                    final_next = s_tlast;
                    state_next = RUN;
                end
            end
            RUN: begin
                if (rem_reg == '0) begin
                    // Pad and emit a partial byte only on a final segment.
                    if (final_reg && (coder_stat.pending != 2'd0)) begin
                        state_next = FLUSH;
                    end else begin
                        state_next = IDLE;
                    end
                end else if (!coder_stat.byte_full || out_free) begin
                    // A step that completes a byte waits until the output can take it.
                    coder_ctrl.step = 1'b1;
                    rem_next        = rem_after;
                    if (coder_stat.byte_full) begin
                        m_valid_next = 1'b1;
                        m_data_next  = coder_stat.byte_value;
                        m_last_next  = !more_bytes;
                    end
                end
            end
            FLUSH: begin
                if (out_free) begin
                    coder_ctrl.clear = 1'b1;
                    m_valid_next     = 1'b1;
                    m_data_next      = coder_stat.partial;
                    m_last_next      = 1'b1;
                    state_next       = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            rem_reg     <= '0;
            final_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rem_reg     <= rem_next;
            final_reg   <= final_next;
            m_valid_reg <= m_valid_next;
        end
        data_reg   <= data_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // The bit cursor is exhausted whenever the sequencer waits for a segment.
    a_idle_cursor_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == IDLE) |-> (rem_reg == '0))
        else $error("bit cursor not empty in idle");

    // A flush always leaves the coder empty.
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FLUSH && out_free) |=> (coder_stat.pending == 2'd0))
        else $error("coder not empty after flush");

    // Completing a byte while the output is blocked must not advance the coder.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (coder_ctrl.step && coder_stat.byte_full) |-> out_free)
        else $error("byte completed while output register busy");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for manchester_byte_packer: directed and random segments,
// random idling on both sides and a long receiver hold-off, checked against a predictor.
// Depends on mbp_pkg and the manchester_byte_packer RTL.
`timescale 1ns / 1ps

module testbench;
    import mbp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no item accepted on either side
    localparam int DRAIN_CYCLES   = 100;    // a full segment plus flush plus latency, with margin
    localparam int RANDOM_ITEMS   = 355;
    localparam int HOLD_AT_BYTE   = 300;    // receiver hold-off starts after this many bytes
    localparam int HOLD_CYCLES    = 250;
    localparam int MAX_PRINTS     = 200;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       run_end;
    } coded_byte_t;

    // Keeps the packer state and the queue of bytes still to come out.
    class byte_scoreboard;
        logic [7:0]  acc_byte;
        logic [1:0]  acc_pairs;
        coded_byte_t due_bytes[$];
        int          errors;

        function new();
            acc_byte  = '0;
            acc_pairs = '0;
            errors    = 0;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("%0t ns: mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // Codes one accepted segment and queues every byte that it completes.
        function void note_segment(logic [63:0] word, logic [6:0] count, logic flush);
            int          n;
            logic [1:0]  pair;
            logic [7:0]  made[$];
            coded_byte_t cb;
            n = (count > SEGMENT_WIDTH) ? SEGMENT_WIDTH : int'(count);
            for (int i = 0; i < n; i++) begin
                pair = word[n - 1 - i] ? LINE_ONE : LINE_ZERO;
                acc_byte = acc_byte | (8'(pair) << (6 - 2 * acc_pairs));
                if (acc_pairs == 2'd3) begin
                    made.push_back(acc_byte);
                    acc_byte  = '0;
                    acc_pairs = '0;
                end else begin
                    acc_pairs = acc_pairs + 2'd1;
                end
            end
            // A final segment pads a partly filled byte, but only if one exists.
            if (flush && acc_pairs != 2'd0) begin
                made.push_back(acc_byte);
                acc_byte  = '0;
                acc_pairs = '0;
            end
            foreach (made[k]) begin
                cb.line_byte = made[k];
                cb.run_end   = (k == made.size() - 1);
                due_bytes.push_back(cb);
            end
        endfunction

        task check_byte(logic [7:0] line_byte, logic run_end);
            coded_byte_t want;
            if (due_bytes.size() == 0) begin
                report($sformatf("unexpected byte %02h run_end %0b", line_byte, run_end));
            end else begin
                want = due_bytes.pop_front();
                if (line_byte !== want.line_byte)
                    report($sformatf("line_byte %02h, expected %02h",
                                     line_byte, want.line_byte));
                if (run_end !== want.run_end)
                    report($sformatf("run_end %0b, expected %0b on byte %02h",
                                     run_end, want.run_end, want.line_byte));
            end
        endtask

        function int waiting();
            return due_bytes.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic [71:0] s_tdata  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        s_tready;
    logic [7:0]  m_tdata;
    logic        m_tvalid;
    logic        m_tlast;
    logic        m_tready = 1'b0;

    byte_scoreboard sb = new();
    bit             send_calm = 1'b0;
    int             bytes_seen = 0;
    int             hold_left = 0;
    bit             hold_done = 1'b0;
    int             quiet_cycles = 0;

    always #6 aclk = ~aclk;

    manchester_byte_packer i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tlast (s_tlast),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tlast (m_tlast),
        .m_tready(m_tready)
    );

    // Offers one segment, idling at random first, and waits for it to be taken.
    task send_segment(logic [63:0] word, logic [6:0] count, logic flush);
        while (!send_calm && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, count, word};
        s_tlast  <= flush;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_segment(word, count, flush);
    endtask

    function automatic logic [63:0] pick_word();
        case ($urandom_range(9))
            0:       return '1;
            1:       return '0;
            2:       return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [6:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 5)  return 7'd0;
        if (r < 10) return 7'($urandom_range(127, 65));
        if (r < 20) return 7'd64;
        if (r < 50) return 7'($urandom_range(8, 1));
        return 7'($urandom_range(64, 1));
    endfunction

    // Receiver: checks every accepted byte, stalls at random, and once holds off
    // long enough that the packer fills up and stops taking segments.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                sb.check_byte(m_tdata, m_tlast);
                bytes_seen++;
            end
            if (!hold_done && bytes_seen >= HOLD_AT_BYTE) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (bytes_seen >= 900 && bytes_seen < 1300) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 34);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part.
        send_segment('1, 7'd64, 1'b0);                        // sixteen bytes of ones
        send_segment('0, 7'd64, 1'b1);                        // final with nothing pending
        send_segment(64'h1, 7'd1, 1'b0);                      // no byte completes
        send_segment('1, 7'd0, 1'b1);                         // zero count flushes a pair
        send_segment('1, 7'd0, 1'b1);                         // flush with nothing pending
        send_segment('0, 7'd0, 1'b0);                         // does nothing at all
        send_segment(64'hFFFF_FFFF_FFFF_FFF5, 7'd3, 1'b1);    // high bits ignored, pad
        send_segment({$urandom, $urandom}, 7'd127, 1'b1);     // count saturates
        send_segment({$urandom, $urandom}, 7'd65, 1'b0);
        send_segment(64'hDEAD_BEEF_0000_0013, 7'd5, 1'b0);
        send_segment(64'h8000_0000_0000_0055, 7'd7, 1'b1);
        send_segment(64'hA, 7'd4, 1'b1);                      // exact byte, no padding
        send_segment(64'h2, 7'd2, 1'b0);
        send_segment(64'h1, 7'd2, 1'b0);
        send_segment('0, 7'd0, 1'b0);
        send_segment({$urandom, $urandom}, 7'd63, 1'b1);
        send_segment('1, 7'd100, 1'b0);
        send_segment(64'h5555_5555_5555_5555, 7'd64, 1'b1);
        send_segment(64'h1, 7'd1, 1'b0);
        send_segment(64'h0, 7'd1, 1'b0);
        send_segment(64'h1, 7'd1, 1'b0);
        send_segment(64'h7, 7'd3, 1'b1);

        // Random part, with a stretch where the sender never idles.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_calm = (n >= 200 && n < 280);
            send_segment(pick_word(), pick_count(), ($urandom_range(99) < 30));
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (sb.waiting() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
